>>> design/sh768_pkg.sv
package sh768_pkg;

  typedef logic [95:0][15:0] lanes_t;

  typedef struct packed {
    logic [63:0] message_word;
    logic [6:0]  valid_bits;
    logic        last_word;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFORM,
    ST_SQZ,
    ST_LAST
  } state_t;

  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_SQZ,
    AFT_LAST
  } after_t;

  localparam int ROUNDS = 9;
  localparam int BLOCK_WORDS = 11;
  localparam int PAD_TOP = 703;

  localparam logic [7:0][15:0] ROUND_CONST = {
    16'h243F, 16'h6A88, 16'h85A3, 16'h08D3,
    16'h1319, 16'h8A2E, 16'h0370, 16'h7344
  };

  function automatic logic [15:0] ror16(input logic [15:0] x, input logic [3:0] n);
    logic [31:0] d;
    d = {x, x} >> n;
    return d[15:0];
  endfunction

  function automatic lanes_t and_rot(input lanes_t s, input int src, input int dst,
                                     input logic [3:0] a, input logic [3:0] b,
                                     input logic [3:0] c);
    lanes_t r;
    logic [15:0] x;
    r = s;
    for (int k = 0; k < 48; k++) begin
      x = s[src + k];
      r[dst + k] = s[dst + k] ^ ((ror16(x, a) & ror16(x, b)) ^ ror16(x, c));
    end
    return r;
  endfunction

  function automatic lanes_t cross_mix(input lanes_t s);
    lanes_t r;
    r = s;
    for (int l = 0; l < 16; l++) begin
      for (int p = 0; p < 6; p++) begin
        r[16 * p + l] = s[16 * p + l] ^ s[16 * ((p + 1) % 6) + l]
                        ^ s[16 * ((p + 4) % 6) + l];
      end
    end
    return r;
  endfunction

  function automatic lanes_t swap_row_pairs(input lanes_t s);
    lanes_t r;
    r = s;
    for (int q = 6; q < 12; q += 2) begin
      for (int j = 0; j < 8; j++) begin
        r[8 * q + j] = s[8 * (q + 1) + j];
        r[8 * (q + 1) + j] = s[8 * q + j];
      end
    end
    return r;
  endfunction

  function automatic lanes_t mix_cols(input lanes_t t);
    lanes_t r;
    logic [15:0] a;
    r = t;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 8; j++) begin
        a = t[8 * (2 + i) + j] ^ t[8 * (4 + i) + j];
        r[8 * i + j] = a;
        r[8 * (2 + i) + j] = t[8 * i + j] ^ t[8 * (4 + i) + j];
        r[8 * (4 + i) + j] = t[8 * i + j] ^ a;
        a = t[8 * (6 + i) + j] ^ t[8 * (10 + i) + j];
        r[8 * (6 + i) + j] = a;
        r[8 * (8 + i) + j] = t[8 * (8 + i) + j] ^ t[8 * (10 + i) + j];
        r[8 * (10 + i) + j] = t[8 * (8 + i) + j] ^ a;
      end
    end
    return r;
  endfunction

  function automatic lanes_t shift_slices(input lanes_t s, input int up, input int down);
    lanes_t r;
    r = s;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 8; j++) begin
        r[up + 8 * i + j] = s[up + 8 * i + ((j + i) & 7)];
        r[down + 8 * i + j] = s[down + 8 * i + ((j + 8 - i) & 7)];
      end
    end
    return r;
  endfunction

  function automatic lanes_t mix_rows(input lanes_t s);
    lanes_t r;
    for (int q = 0; q < 12; q++) begin
      for (int k = 0; k < 8; k++) begin
        r[8 * q + k] = s[8 * q + ((k + 6) & 7)] ^ s[8 * q + k] ^ s[8 * q + ((k + 2) & 7)];
      end
    end
    return r;
  endfunction

  function automatic lanes_t add_const(input lanes_t s, input logic [4:0] rn);
    lanes_t r;
    r = s;
    for (int j = 0; j < 8; j++) begin
      r[j] = s[j] ^ ROUND_CONST[j] ^ {11'd0, rn};
    end
    return r;
  endfunction

  function automatic lanes_t swap_halves(input lanes_t s);
    lanes_t r;
    for (int k = 0; k < 48; k++) begin
      r[k] = s[k + 48];
      r[k + 48] = s[k];
    end
    return r;
  endfunction

  function automatic lanes_t fwd_round(input lanes_t s_in, input logic [4:0] rn);
    lanes_t s;
    s = cross_mix(s_in);
    s = swap_row_pairs(s);
    s = and_rot(s, 0, 48, 4'd0, 4'd1, 4'd8);
    s = and_rot(s, 48, 0, 4'd14, 4'd5, 4'd0);
    s = and_rot(s, 0, 48, 4'd9, 4'd12, 4'd8);
    s = and_rot(s, 48, 0, 4'd14, 4'd5, 4'd0);
    s = and_rot(s, 0, 48, 4'd0, 4'd1, 4'd8);
    s = and_rot(s, 48, 0, 4'd8, 4'd9, 4'd0);
    s = cross_mix(s);
    s = swap_row_pairs(s);
    s = mix_cols(s);
    s = shift_slices(s, 0, 48);
    s = mix_rows(s);
    s = add_const(s, rn);
    return s;
  endfunction

  function automatic lanes_t inv_round(input lanes_t s_in, input logic [4:0] rn);
    lanes_t s;
    s = add_const(s_in, rn);
    s = mix_rows(s);
    s = shift_slices(s, 48, 0);
    s = mix_cols(s);
    s = swap_row_pairs(s);
    s = cross_mix(s);
    s = and_rot(s, 48, 0, 4'd8, 4'd9, 4'd0);
    s = and_rot(s, 0, 48, 4'd0, 4'd1, 4'd8);
    s = and_rot(s, 48, 0, 4'd14, 4'd5, 4'd0);
    s = and_rot(s, 0, 48, 4'd9, 4'd12, 4'd8);
    s = and_rot(s, 48, 0, 4'd14, 4'd5, 4'd0);
    s = and_rot(s, 0, 48, 4'd0, 4'd1, 4'd8);
    s = swap_halves(s);
    s = swap_row_pairs(s);
    s = cross_mix(s);
    return s;
  endfunction

endpackage

>>> design/sh768_round.sv
module sh768_round (
  input  sh768_pkg::lanes_t fw_i,
  input  sh768_pkg::lanes_t iv_i,
  input  logic [3:0]        rnd_i,
  output sh768_pkg::lanes_t fw_o,
  output sh768_pkg::lanes_t iv_o
);

  logic [4:0] inv_rn;

  assign inv_rn = 5'(2 * sh768_pkg::ROUNDS - 1) - {1'b0, rnd_i};
  assign fw_o = sh768_pkg::fwd_round(fw_i, {1'b0, rnd_i});
  assign iv_o = sh768_pkg::inv_round(iv_i, inv_rn);

endmodule

>>> design/sponge_hash_768.sv
// Streaming 768-bit sponge hash.
// Input channel: one 64-bit message word per accepted word, first byte in the low bits.
// The final word of a message has last_word set and valid_bits giving its valid low bits.
// Output channel: twelve digest words, the twelfth marked with digest_last.
// A plain word is XORed into the state; the eleventh word of a block starts the
// transform, one forward and one inverse round per cycle in a single shared round
// unit. The block accepts no word while the transform runs.
// The final word starts a transform, and a second one when padding spills into an extra
// block, before the first digest word appears. Digest words 0 to 10 then leave one per
// accepted word, a further transform follows, and the last word is shown.
// While the receiver stalls, the digest word is held and the block waits.
// After the last digest word the sponge state is cleared for the next message.
// Reset clears the sponge state and returns the block to idle; there is no
// clearing pass.
module sponge_hash_768 (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sh768_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sh768_pkg::out_t  out_data
);

  sh768_pkg::state_t state_r, state_nxt;
  sh768_pkg::after_t after_r, after_nxt;
  logic [1535:0]     st_r, st_nxt;
  logic [1535:0]     iv_r, iv_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [3:0]        rnd_r, rnd_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              pad0_r, pad0_nxt;
  sh768_pkg::lanes_t fw_o, iv_o;
  logic [1535:0]     tmp;
  logic [1535:0]     mix;
  logic [63:0]       w;
  logic [6:0]        vb;
  logic [9:0]        p;

  sh768_round u_round (
    .fw_i  (st_r),
    .iv_i  (iv_r),
    .rnd_i (rnd_r),
    .fw_o  (fw_o),
    .iv_o  (iv_o)
  );

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    st_nxt    = st_r;
    iv_nxt    = iv_r;
    idx_nxt   = idx_r;
    rnd_nxt   = rnd_r;
    cnt_nxt   = cnt_r;
    pad0_nxt  = pad0_r;
    tmp       = st_r;
    mix       = fw_o ^ iv_o;
    w         = in_data.message_word;
    vb        = (in_data.valid_bits > 7'd64) ? 7'd64 : in_data.valid_bits;
    p         = {idx_r, 6'd0} + {3'd0, vb};
    case (state_r)
      sh768_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!in_data.last_word) begin
            tmp[{idx_r, 6'd0} +: 64] = st_r[{idx_r, 6'd0} +: 64] ^ w;
            st_nxt = tmp;
            if (idx_r == 4'(sh768_pkg::BLOCK_WORDS - 1)) begin
              iv_nxt    = tmp;
              rnd_nxt   = 4'd0;
              idx_nxt   = 4'd0;
              after_nxt = sh768_pkg::AFT_IDLE;
              state_nxt = sh768_pkg::ST_XFORM;
            end else begin
              idx_nxt = idx_r + 4'd1;
            end
          end else begin
            if (vb < 7'd64) begin
              w = w & ((64'd1 << vb[5:0]) - 64'd1);
            end
            tmp[{idx_r, 6'd0} +: 64] = st_r[{idx_r, 6'd0} +: 64] ^ w;
            if (p == 10'(sh768_pkg::PAD_TOP + 1)) begin
              after_nxt = sh768_pkg::AFT_PAD;
              pad0_nxt  = 1'b1;
            end else if (p == 10'(sh768_pkg::PAD_TOP)) begin
              tmp[sh768_pkg::PAD_TOP] = 1'b1;
              after_nxt = sh768_pkg::AFT_PAD;
              pad0_nxt  = 1'b0;
            end else begin
              tmp[p] = 1'b1;
              tmp[sh768_pkg::PAD_TOP] = 1'b1;
              after_nxt = sh768_pkg::AFT_SQZ;
            end
            st_nxt    = tmp;
            iv_nxt    = tmp;
            rnd_nxt   = 4'd0;
            idx_nxt   = 4'd0;
            state_nxt = sh768_pkg::ST_XFORM;
          end
        end
      end
      sh768_pkg::ST_XFORM: begin
        if (rnd_r == 4'(sh768_pkg::ROUNDS - 1)) begin
          rnd_nxt = 4'd0;
          case (after_r)
            sh768_pkg::AFT_IDLE: begin
              st_nxt    = mix;
              state_nxt = sh768_pkg::ST_IDLE;
            end
            sh768_pkg::AFT_PAD: begin
              mix[0] = mix[0] | pad0_r;
              mix[sh768_pkg::PAD_TOP] = 1'b1;
              st_nxt    = mix;
              iv_nxt    = mix;
              after_nxt = sh768_pkg::AFT_SQZ;
            end
            sh768_pkg::AFT_SQZ: begin
              st_nxt    = mix;
              cnt_nxt   = 4'd0;
              state_nxt = sh768_pkg::ST_SQZ;
            end
            default: begin
              st_nxt    = mix;
              state_nxt = sh768_pkg::ST_LAST;
            end
          endcase
        end else begin
          st_nxt  = fw_o;
          iv_nxt  = iv_o;
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      sh768_pkg::ST_SQZ: begin
        if (!out_stall) begin
          if (cnt_r == 4'(sh768_pkg::BLOCK_WORDS - 1)) begin
            iv_nxt    = st_r;
            rnd_nxt   = 4'd0;
            after_nxt = sh768_pkg::AFT_LAST;
            state_nxt = sh768_pkg::ST_XFORM;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      sh768_pkg::ST_LAST: begin
        if (!out_stall) begin
          st_nxt    = '0;
          state_nxt = sh768_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sh768_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state_r != sh768_pkg::ST_IDLE);
    out_valid = (state_r == sh768_pkg::ST_SQZ) || (state_r == sh768_pkg::ST_LAST);
    out_data.digest_last = (state_r == sh768_pkg::ST_LAST);
    if (state_r == sh768_pkg::ST_LAST) begin
      out_data.digest_word = st_r[63:0];
    end else begin
      out_data.digest_word = st_r[{cnt_r, 6'd0} +: 64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sh768_pkg::ST_IDLE;
      after_r <= sh768_pkg::AFT_IDLE;
      st_r    <= '0;
      idx_r   <= 4'd0;
      rnd_r   <= 4'd0;
      cnt_r   <= 4'd0;
      pad0_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      st_r    <= st_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
      cnt_r   <= cnt_nxt;
      pad0_r  <= pad0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iv_r <= iv_nxt;
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  class digest_board;
    logic [63:0]      hash_state [24];
    int               word_pos;
    sh768_pkg::out_t  pending_digest [$];
    int               errors;

    function new();
      foreach (hash_state[i]) hash_state[i] = '0;
      word_pos = 0;
      errors = 0;
    endfunction

    function automatic logic [15:0] rotr(logic [15:0] x, int n);
      n = n & 15;
      if (n == 0) return x;
      return (x >> n) | (x << (16 - n));
    endfunction

    function automatic void chi_step(ref logic [15:0] s [96], input int src, input int dst,
                                     input int a, input int b, input int c);
      logic [15:0] x;
      for (int k = 0; k < 48; k++) begin
        x = s[src + k];
        s[dst + k] ^= (rotr(x, a) & rotr(x, b)) ^ rotr(x, c);
      end
    endfunction

    function automatic void column_xor(ref logic [15:0] s [96]);
      logic [15:0] x [6];
      for (int l = 0; l < 16; l++) begin
        for (int p = 0; p < 6; p++) x[p] = s[16 * p + l];
        for (int p = 0; p < 6; p++) s[16 * p + l] = x[p] ^ x[(p + 1) % 6] ^ x[(p + 4) % 6];
      end
    endfunction

    function automatic void row_swap(ref logic [15:0] s [96]);
      logic [15:0] t;
      for (int r = 6; r < 12; r += 2)
        for (int j = 0; j < 8; j++) begin
          t = s[8 * r + j];
          s[8 * r + j] = s[8 * (r + 1) + j];
          s[8 * (r + 1) + j] = t;
        end
    endfunction

    function automatic void col_mix(ref logic [15:0] s [96]);
      logic [15:0] t [96];
      logic [15:0] a;
      t = s;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 8; j++) begin
          a = t[8 * (2 + i) + j] ^ t[8 * (4 + i) + j];
          s[8 * i + j] = a;
          s[8 * (2 + i) + j] = t[8 * i + j] ^ t[8 * (4 + i) + j];
          s[8 * (4 + i) + j] = t[8 * i + j] ^ a;
          a = t[8 * (6 + i) + j] ^ t[8 * (10 + i) + j];
          s[8 * (6 + i) + j] = a;
          s[8 * (8 + i) + j] = t[8 * (8 + i) + j] ^ t[8 * (10 + i) + j];
          s[8 * (10 + i) + j] = t[8 * (8 + i) + j] ^ a;
        end
    endfunction

    function automatic void slice_shift(ref logic [15:0] s [96], input int up, input int dn);
      logic [15:0] v [8];
      for (int i = 0; i < 6; i++) begin
        for (int j = 0; j < 8; j++) v[j] = s[up + 8 * i + j];
        for (int j = 0; j < 8; j++) s[up + 8 * i + j] = v[(j + i) & 7];
        for (int j = 0; j < 8; j++) v[j] = s[dn + 8 * i + j];
        for (int j = 0; j < 8; j++) s[dn + 8 * i + j] = v[(j + 8 - i) & 7];
      end
    endfunction

    function automatic void row_mix(ref logic [15:0] s [96]);
      logic [15:0] t [8];
      for (int r = 0; r < 12; r++) begin
        for (int k = 0; k < 8; k++) t[k] = s[8 * r + k];
        for (int k = 0; k < 8; k++) s[8 * r + k] = t[(k + 6) & 7] ^ t[k] ^ t[(k + 2) & 7];
      end
    endfunction

    function automatic void const_add(ref logic [15:0] s [96], input int rn);
      for (int j = 0; j < 8; j++) s[j] ^= sh768_pkg::ROUND_CONST[j] ^ 16'(rn);
    endfunction

    function automatic void forward_pass(ref logic [15:0] s [96], input int rn);
      column_xor(s); row_swap(s);
      chi_step(s, 0, 48, 0, 1, 8); chi_step(s, 48, 0, 14, 5, 0);
      chi_step(s, 0, 48, 9, 12, 8); chi_step(s, 48, 0, 14, 5, 0);
      chi_step(s, 0, 48, 0, 1, 8); chi_step(s, 48, 0, 8, 9, 0);
      column_xor(s); row_swap(s); col_mix(s); slice_shift(s, 0, 48); row_mix(s);
      const_add(s, rn);
    endfunction

    function automatic void backward_pass(ref logic [15:0] s [96], input int rn);
      logic [15:0] t;
      const_add(s, rn); row_mix(s); slice_shift(s, 48, 0); col_mix(s); row_swap(s);
      column_xor(s);
      chi_step(s, 48, 0, 8, 9, 0); chi_step(s, 0, 48, 0, 1, 8);
      chi_step(s, 48, 0, 14, 5, 0); chi_step(s, 0, 48, 9, 12, 8);
      chi_step(s, 48, 0, 14, 5, 0); chi_step(s, 0, 48, 0, 1, 8);
      for (int k = 0; k < 48; k++) begin
        t = s[k]; s[k] = s[k + 48]; s[k + 48] = t;
      end
      row_swap(s); column_xor(s);
    endfunction

    function void permute();
      logic [15:0] fw [96];
      logic [15:0] iv [96];
      for (int k = 0; k < 96; k++) fw[k] = hash_state[k / 4][16 * (k % 4) +: 16];
      iv = fw;
      for (int r = 0; r < sh768_pkg::ROUNDS; r++) begin
        forward_pass(fw, r);
        backward_pass(iv, sh768_pkg::ROUNDS - 1 - r + sh768_pkg::ROUNDS);
      end
      for (int k = 0; k < 96; k++) hash_state[k / 4][16 * (k % 4) +: 16] = fw[k] ^ iv[k];
    endfunction

    function void set_bit(int p);
      hash_state[(p / 64) % sh768_pkg::BLOCK_WORDS][p % 64] = 1'b1;
    endfunction

    function void note_word(sh768_pkg::in_t w);
      logic [63:0] m;
      int vb;
      int p;
      sh768_pkg::out_t d;
      m = w.message_word;
      if (!w.last_word) begin
        hash_state[word_pos] ^= m;
        word_pos++;
        if (word_pos == sh768_pkg::BLOCK_WORDS) begin
          permute();
          word_pos = 0;
        end
        return;
      end
      vb = (w.valid_bits > 64) ? 64 : int'(w.valid_bits);
      if (vb < 64) m &= (64'd1 << vb) - 64'd1;
      hash_state[word_pos] ^= m;
      p = word_pos * 64 + vb;
      if (p == sh768_pkg::PAD_TOP + 1) begin
        permute(); set_bit(0); set_bit(sh768_pkg::PAD_TOP);
      end else if (p == sh768_pkg::PAD_TOP) begin
        set_bit(sh768_pkg::PAD_TOP); permute(); set_bit(sh768_pkg::PAD_TOP);
      end else begin
        set_bit(p); set_bit(sh768_pkg::PAD_TOP);
      end
      permute();
      for (int k = 0; k < sh768_pkg::BLOCK_WORDS; k++) begin
        d.digest_word = hash_state[k];
        d.digest_last = 1'b0;
        pending_digest.push_back(d);
      end
      permute();
      d.digest_word = hash_state[0];
      d.digest_last = 1'b1;
      pending_digest.push_back(d);
      foreach (hash_state[i]) hash_state[i] = '0;
      word_pos = 0;
    endfunction

    function void check_word(sh768_pkg::out_t got);
      sh768_pkg::out_t want;
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest word %h/%b", $time, got.digest_word, got.digest_last);
        errors++;
        return;
      end
      want = pending_digest.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $display("%0t: digest_word expected %h actual %h", $time, want.digest_word,
                 got.digest_word);
        errors++;
      end
      if (got.digest_last !== want.digest_last) begin
        $display("%0t: digest_last expected %b actual %b", $time, want.digest_last,
                 got.digest_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sh768_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sh768_pkg::out_t out_data;

  digest_board board = new();
  int   cycle_count = 0;
  int   out_wait = 0;

  always #1 clk = ~clk;

  sponge_hash_768 DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  task automatic send_word(logic [63:0] m, logic [6:0] vb, logic lw);
    sh768_pkg::in_t w;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.message_word = m;
    w.valid_bits = vb;
    w.last_word = lw;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.note_word(w);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_message(int full_words, logic [6:0] vb);
    for (int i = 0; i < full_words; i++) send_word(rand_word(), 7'($urandom), 1'b0);
    send_word(rand_word(), vb, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_word(out_data);
      out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    end else if (out_valid && out_wait > 0) begin
      out_wait--;
    end
    out_stall <= (out_wait > 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_message(0, 7'd0);
    send_message(0, 7'd64);
    send_message(0, 7'd127);
    send_message(9, 7'd63);
    send_message(10, 7'd63);
    send_message(10, 7'd64);
    send_message(10, 7'd0);
    send_word('1, 7'd1, 1'b1);
    sent = 0;
    while (sent < 100) begin
      case ($urandom_range(0, 3))
        0: n = $urandom_range(0, 3);
        1: n = $urandom_range(9, 12);
        default: n = $urandom_range(0, 24);
      endcase
      send_message(n, ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64)));
      sent += n + 1;
    end
    in_valid <= 1'b0;
    while (board.pending_digest.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
design/sh768_pkg.sv
design/sh768_round.sv
design/sponge_hash_768.sv
test/testbench.sv
